@@ rtl/core/tdpc_pkg.sv @@
package tdpc_pkg;

  localparam int DEFAULT_NUM_WIDTH = 32;

  // Wheel of 30: candidates that survive 2, 3 and 5 are only tested
  // against base + offset for these eight offsets.
  localparam int WHEEL_STEP  = 30;
  localparam int WHEEL_SLOTS = 8;
  localparam int SLOT_BITS   = 3;
  localparam int OFFSET_BITS = 5;

  localparam int PRIME_TWO   = 2;
  localparam int PRIME_THREE = 3;
  localparam int PRIME_FIVE  = 5;

  // Slot 0 (offset one) gives no useful divisor at base 0, so the trial loop
  // begins at slot 1, which is the first divisor above five.
  localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(1);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(WHEEL_SLOTS - 1);

  function automatic logic [OFFSET_BITS-1:0] wheel_offset(input logic [SLOT_BITS-1:0] slot);
    logic [OFFSET_BITS-1:0] off;
    unique case (slot)
      3'd0:    off = 5'd1;
      3'd1:    off = 5'd7;
      3'd2:    off = 5'd11;
      3'd3:    off = 5'd13;
      3'd4:    off = 5'd17;
      3'd5:    off = 5'd19;
      3'd6:    off = 5'd23;
      default: off = 5'd29;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/core/tdpc_div.sv @@
module tdpc_div #(
  parameter int NUM_WIDTH = tdpc_pkg::DEFAULT_NUM_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [NUM_WIDTH-1:0] remainder
);

  localparam int W  = NUM_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step per cycle: shift in the next dividend bit and
  // subtract the divisor when the partial remainder allows it.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});

    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/core/trial_division_prime_check.sv @@
// Primality test by trial division on a wheel of 30.
//
// Input: pulse start with the number on in_candidate while busy is low; the
// item is taken at that edge. busy rises in the next cycle unless the result
// is already shown there.
// Output: out_valid is high for exactly one cycle with out_is_prime. The
// receiver cannot hold a result off; it must sample it in that cycle.
// busy falls in the cycle where out_valid is shown, so the next start may
// come together with the result.
//
// 0, 1, 2, 3, 5 and even numbers are answered in the cycle after start.
// Otherwise every step runs through the shared radix-2 divider; Newton and
// trial steps each pass an issue state (S_ROOT_CMP, S_TRIAL) before their
// division. That is two divisions for 3 and 5, about NUM_WIDTH / 2 + 4
// Newton steps for the square root, then one division per wheel divisor up
// to the root (8 per 30). For a 32-bit prime near 2**32 that is roughly 17500
// divisions. The block handles one item at a time.
//
// Reset returns the sequencer to idle and drops any item in progress.
module trial_division_prime_check #(
  parameter int NUM_WIDTH = tdpc_pkg::DEFAULT_NUM_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  output logic                 out_valid,
  output logic                 out_is_prime
);

  localparam int W = NUM_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD3_WAIT,
    S_MOD5_WAIT,
    S_ROOT_CMP,
    S_ROOT_WAIT,
    S_TRIAL,
    S_TRIAL_WAIT
  } state_t;

  state_t state_r;

  logic [W-1:0] n_r;
  logic [W-1:0] cur_r;
  logic [W-1:0] next_r;
  logic [W-1:0] base_r;
  logic [tdpc_pkg::SLOT_BITS-1:0] slot_r;
  logic         div_start_r;
  logic [W-1:0] div_divisor_r;
  logic         out_valid_r;
  logic         out_is_prime_r;

  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic [W-1:0] trial_d;

  tdpc_div #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (n_r),
    .divisor   (div_divisor_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign trial_d = base_r + W'(tdpc_pkg::wheel_offset(slot_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      div_start_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r <= in_candidate;
            if (in_candidate < W'(tdpc_pkg::PRIME_TWO)) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b0;
            end else if (in_candidate == W'(tdpc_pkg::PRIME_TWO) ||
                         in_candidate == W'(tdpc_pkg::PRIME_THREE) ||
                         in_candidate == W'(tdpc_pkg::PRIME_FIVE)) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b1;
            end else if (!in_candidate[0]) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b0;
            end else begin
              div_start_r   <= 1'b1;
              div_divisor_r <= W'(tdpc_pkg::PRIME_THREE);
              state_r       <= S_MOD3_WAIT;
            end
          end
        end
        S_MOD3_WAIT: begin
          if (div_done) begin
            if (div_rem == '0) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b0;
              state_r        <= S_IDLE;
            end else begin
              div_start_r   <= 1'b1;
              div_divisor_r <= W'(tdpc_pkg::PRIME_FIVE);
              state_r       <= S_MOD5_WAIT;
            end
          end
        end
        S_MOD5_WAIT: begin
          if (div_done) begin
            if (div_rem == '0) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b0;
              state_r        <= S_IDLE;
            end else begin
              // Newton iteration starts from n and ceil(n / 2).
              cur_r   <= n_r;
              next_r  <= (n_r >> 1) + W'(n_r[0]);
              state_r <= S_ROOT_CMP;
            end
          end
        end
        S_ROOT_CMP: begin
          if (next_r < cur_r) begin
            cur_r         <= next_r;
            div_start_r   <= 1'b1;
            div_divisor_r <= next_r;
            state_r       <= S_ROOT_WAIT;
          end else begin
            // cur_r now holds the integer square root.
            base_r  <= '0;
            slot_r  <= tdpc_pkg::FIRST_SLOT;
            state_r <= S_TRIAL;
          end
        end
        S_ROOT_WAIT: begin
          if (div_done) begin
            // Floor of (cur + n / cur) / 2 without a carry out.
            next_r  <= (cur_r & div_quo) + ((cur_r ^ div_quo) >> 1);
            state_r <= S_ROOT_CMP;
          end
        end
        S_TRIAL: begin
          if (trial_d > cur_r) begin
            out_valid_r    <= 1'b1;
            out_is_prime_r <= 1'b1;
            state_r        <= S_IDLE;
          end else begin
            div_start_r   <= 1'b1;
            div_divisor_r <= trial_d;
            state_r       <= S_TRIAL_WAIT;
          end
        end
        S_TRIAL_WAIT: begin
          if (div_done) begin
            if (div_rem == '0) begin
              out_valid_r    <= 1'b1;
              out_is_prime_r <= 1'b0;
              state_r        <= S_IDLE;
            end else begin
              if (slot_r == tdpc_pkg::LAST_SLOT) begin
                slot_r <= '0;
                base_r <= base_r + W'(tdpc_pkg::WHEEL_STEP);
              end else begin
                slot_r <= slot_r + tdpc_pkg::SLOT_BITS'(1);
              end
              state_r <= S_TRIAL;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

@@ rtl/core/tdpc_checker.sv @@
module tdpc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A taken item either answers at once or keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("busy did not rise and no result followed a taken item");

  // The result is shown in the cycle where busy has dropped.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // busy only ends by delivering a result.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy fell without a result");

  // A result only follows a taken item or a busy stretch.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start) || $past(busy))
    else $error("result strobe without an item in progress");

endmodule

bind trial_division_prime_check tdpc_checker u_tdpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_W = tdpc_pkg::DEFAULT_NUM_WIDTH;
  localparam logic [NUM_W-1:0] LARGEST_PRIME = 32'd4294967291;

  typedef struct {
    logic [NUM_W-1:0] candidate;
    bit               is_prime;
  } verdict_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [NUM_W-1:0] in_candidate;
  logic             out_valid;
  logic             out_is_prime;

  verdict_t verdicts_due[$];
  verdict_t oldest_verdict;
  int       mismatches;
  int       items_sent;
  int       verdicts_seen;
  int       primes_sent;

  trial_division_prime_check #(
    .NUM_WIDTH(NUM_W)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Floor of the square root by Newton steps, then trial division on a wheel
  // of 30 with every divisor kept at or below the root.
  function automatic bit primality_of(input logic [NUM_W-1:0] value);
    longint unsigned n;
    longint unsigned root;
    longint unsigned nxt;
    longint unsigned q;
    longint unsigned base;
    longint unsigned divisor;
    longint unsigned offsets [8];
    n = value;
    offsets = '{1, 7, 11, 13, 17, 19, 23, 29};
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3 || n == 5) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0 || n % 5 == 0) return 1'b0;
    root = n;
    nxt = (n >> 1) + (n & 1);
    while (nxt < root) begin
      root = nxt;
      if (root == 0) break;
      q = n / root;
      nxt = (root & q) + ((root ^ q) >> 1);
    end
    for (base = 0; base <= root; base += 30) begin
      foreach (offsets[k]) begin
        divisor = base + offsets[k];
        if (divisor > 5 && divisor <= root && n % divisor == 0) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Start stays high from one item to the next; only a pause or a wait for all verdicts lowers it.
  task automatic send_candidate(input logic [NUM_W-1:0] value);
    verdict_t v;
    @(negedge clk);
    start <= 1'b1;
    in_candidate <= value;
    while (busy) @(negedge clk);
    @(posedge clk);
    v.candidate = value;
    v.is_prime = primality_of(value);
    verdicts_due.push_back(v);
    items_sent++;
    if (v.is_prime) primes_sent++;
  endtask

  task automatic pause_sender(input int idle_pct);
    if ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_candidate <= $urandom;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  endtask

  task automatic wait_all_verdicts();
    @(negedge clk);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [NUM_W-1:0] random_candidate();
    logic [NUM_W-1:0] value;
    int unsigned      pick;
    int unsigned      p;
    int unsigned      f;
    pick = $urandom_range(0, 99);
    value = $urandom;
    if (pick < 50) begin
      value = value & ((32'd1 << $urandom_range(1, 16)) - 1);
    end else if (pick < 75) begin
      // Full-width numbers with a small factor keep the trial loop short.
      case ($urandom_range(0, 5))
        0: p = 2;
        1: p = 3;
        2: p = 5;
        3: p = 7;
        4: p = 11;
        default: p = 13;
      endcase
      value = value - (value % p);
    end else if (pick < 88) begin
      value = value & ((32'd1 << $urandom_range(17, 20)) - 1);
    end else begin
      p = $urandom_range(7, 255) | 1;
      f = $urandom_range(7, 255) | 1;
      value = p * f;
    end
    return value;
  endfunction

  task automatic test_directed_cases();
    logic [NUM_W-1:0] cases [$];
    cases = '{0, 1, 2, 3, 5, 4, 6, 9, 25, 7, 11, 13, 47, 49, 121, 169, 841, 961,
              65537, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555,
              32'hAAAA_AAA9};
    foreach (cases[i]) send_candidate(cases[i]);
    wait_all_verdicts();
  endtask

  // The largest 32-bit prime runs the whole wheel up to a root of 65535.
  task automatic test_largest_prime();
    send_candidate(LARGEST_PRIME);
    wait_all_verdicts();
  endtask

  task automatic test_random_traffic();
    int idle_pct [3];
    idle_pct = '{30, 60, 0};
    foreach (idle_pct[ph]) begin
      for (int i = 0; i < 26; i++) begin
        send_candidate(random_candidate());
        pause_sender(idle_pct[ph]);
        if (ph == 0 && i == 12) wait_all_verdicts();
      end
      wait_all_verdicts();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        $error("is_prime: no item waiting, actual %0b", out_is_prime);
        mismatches++;
      end else begin
        oldest_verdict = verdicts_due.pop_front();
        verdicts_seen++;
        if (out_is_prime !== oldest_verdict.is_prime) begin
          $error("is_prime for %0d: expected %0b, actual %0b",
                 oldest_verdict.candidate, oldest_verdict.is_prime, out_is_prime);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_candidate = '0;
    mismatches = 0;
    items_sent = 0;
    verdicts_seen = 0;
    primes_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_largest_prime();

    wait_all_verdicts();
    repeat (50) @(posedge clk);
    $display("Checked %0d candidates (%0d prime) with %0d verdicts returned,",
             items_sent, primes_sent, verdicts_seen);
    $display("including edge values, wheel squares, sender gaps and the largest prime.");
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
